// ===== rtl/ketu_pkg.sv =====
// shared types and constants for the keyed event table upsert block
// table depth, derived widths, request/result codes, control and status structs
// no dependencies
package ketu_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W   = 32;
  localparam int TIME_W  = 64;
  localparam int LEN_W   = 32;
  localparam int SLOT_W  = 5;
  localparam int COUNT_W = 6;
  localparam int CODE_W  = 3;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic              whole_day;
    logic [LEN_W-1:0]  length_seconds;
    logic [TIME_W-1:0] start_time;
    logic [KEY_W-1:0]  event_key;
  } entry_t;

  typedef enum logic [CODE_W-1:0] {
    OUT_UPDATED  = 3'd0,
    OUT_INSERTED = 3'd1,
    OUT_EVICTED  = 3'd2,
    OUT_DELETED  = 3'd3,
    OUT_ABSENT   = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_TAG_NEXT,
    RS_BEST_NEXT
  } rd_src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MIN,
    ST_SHIFT,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic     latch_req;
    logic     rd_start;
    rd_src_t  rd_src;
    logic     rd_step;
    logic     set_hit;
    logic     min_upd;
    logic     mark_evict;
    logic     shift_wr;
    logic     req_wr;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     out_load;
    outcome_t outcome;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic is_del;
    logic found;
    logic full;
    logic evicted;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/ketu_dpath.sv =====
// datapath: record memory, scan pointer, request, search/min/shift registers, result register
// depends on ketu_pkg
module ketu_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ketu_pkg::ctrl_cmd_t         cmd,
  output ketu_pkg::dp_status_t        status,
  input  logic                        in_is_delete,
  input  ketu_pkg::entry_t            in_entry,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [ketu_pkg::CODE_W-1:0]  out_outcome,
  output logic [ketu_pkg::SLOT_W-1:0]  out_slot,
  output logic [ketu_pkg::KEY_W-1:0]   out_evicted,
  output logic [ketu_pkg::COUNT_W-1:0] out_count
);
  import ketu_pkg::*;

  entry_t mem [TABLE_DEPTH];

  entry_t             req_r;
  logic               del_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   ptr_r;
  logic [IDX_W-1:0]   tag_r;
  logic               pend_r;
  entry_t             rd_data_r;
  logic               found_r;
  logic               evict_r;
  logic [IDX_W-1:0]   slot_r;
  logic [IDX_W-1:0]   best_r;
  logic [TIME_W-1:0]  best_time_r;
  logic [KEY_W-1:0]   best_key_r;
  logic               out_valid_r;
  logic [CODE_W-1:0]  out_outcome_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [KEY_W-1:0]   out_evicted_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               rd_issue;
  logic [CNT_W-1:0]   start_ptr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               time_less;
  logic               out_valid_nxt;

  assign rd_issue  = cmd.rd_step && (ptr_r != count_r);
  assign time_less = $signed(rd_data_r.start_time) < $signed(best_time_r);

  always_comb begin
    case (cmd.rd_src)
      RS_ZERO:      start_ptr = '0;
      RS_TAG_NEXT:  start_ptr = CNT_W'(tag_r) + CNT_W'(1);
      RS_BEST_NEXT: start_ptr = CNT_W'(best_r) + CNT_W'(1);
      default:      start_ptr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = req_r;
    if (cmd.shift_wr && pend_r) begin
      wr_en   = 1'b1;
      wr_addr = tag_r - IDX_W'(1);
      wr_data = rd_data_r;
    end else if (cmd.req_wr) begin
      wr_en   = 1'b1;
      wr_addr = found_r ? slot_r : count_r[IDX_W-1:0];
      wr_data = req_r;
    end
  end

  // record memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      rd_data_r <= mem[ptr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r <= in_entry;
      del_r <= in_is_delete;
    end
    if (rd_issue) begin
      tag_r <= ptr_r[IDX_W-1:0];
    end
    if (cmd.min_upd && pend_r && (tag_r == '0 || time_less)) begin
      best_r      <= tag_r;
      best_time_r <= rd_data_r.start_time;
      best_key_r  <= rd_data_r.event_key;
    end
    if (cmd.latch_req) begin
      slot_r <= '0;
    end else if (cmd.set_hit) begin
      slot_r <= tag_r;
    end else if (cmd.req_wr) begin
      slot_r <= wr_addr;
    end
    if (cmd.out_load) begin
      out_outcome_r <= cmd.outcome;
      out_slot_r    <= SLOT_W'(slot_r);
      out_evicted_r <= evict_r ? best_key_r : '0;
      out_count_r   <= COUNT_W'(count_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      evict_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.rd_start) begin
        ptr_r  <= start_ptr;
        pend_r <= 1'b0;
      end else begin
        pend_r <= rd_issue;
        if (rd_issue) begin
          ptr_r <= ptr_r + CNT_W'(1);
        end
      end
      if (cmd.latch_req) begin
        found_r <= 1'b0;
        evict_r <= 1'b0;
      end else begin
        if (cmd.set_hit) begin
          found_r <= 1'b1;
        end
        if (cmd.mark_evict) begin
          evict_r <= 1'b1;
        end
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  assign status.hit      = pend_r && (rd_data_r.event_key == req_r.event_key);
  assign status.scan_end = !pend_r && (ptr_r == count_r);
  assign status.is_del   = del_r;
  assign status.found    = found_r;
  assign status.full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign status.evicted  = evict_r;
  assign status.out_busy = out_valid_r && !out_tready;

  assign out_tvalid  = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_slot    = out_slot_r;
  assign out_evicted = out_evicted_r;
  assign out_count   = out_count_r;

endmodule

// ===== rtl/ketu_ctrl.sv =====
// controller: sequences search, oldest-record scan, shift-down and write for one request
// depends on ketu_pkg
module ketu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  ketu_pkg::dp_status_t status,
  output ketu_pkg::ctrl_cmd_t  cmd
);
  import ketu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.hit) begin
          state_nxt = status.is_del ? ST_SHIFT : ST_WRITE;
        end else if (status.scan_end) begin
          if (status.is_del) begin
            state_nxt = ST_FINISH;
          end else if (status.full) begin
            state_nxt = ST_MIN;
          end else begin
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_MIN: begin
        if (status.scan_end) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (status.scan_end) begin
          state_nxt = status.is_del ? ST_FINISH : ST_WRITE;
        end
      end
      ST_WRITE: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_src  = RS_ZERO;
    cmd.outcome = OUT_UPDATED;
    in_tready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.latch_req = in_tvalid;
        cmd.rd_start  = in_tvalid;
      end
      ST_SEARCH: begin
        cmd.rd_step = 1'b1;
        if (status.hit) begin
          cmd.set_hit  = 1'b1;
          cmd.rd_start = status.is_del;
          cmd.rd_src   = RS_TAG_NEXT;
        end else if (status.scan_end && !status.is_del && status.full) begin
          cmd.rd_start = 1'b1;
        end
      end
      ST_MIN: begin
        cmd.rd_step = 1'b1;
        cmd.min_upd = 1'b1;
        if (status.scan_end) begin
          cmd.mark_evict = 1'b1;
          cmd.rd_start   = 1'b1;
          cmd.rd_src     = RS_BEST_NEXT;
        end
      end
      ST_SHIFT: begin
        cmd.rd_step  = 1'b1;
        cmd.shift_wr = 1'b1;
        cmd.cnt_dec  = status.scan_end;
      end
      ST_WRITE: begin
        cmd.req_wr  = 1'b1;
        cmd.cnt_inc = !status.found;
      end
      ST_FINISH: begin
        cmd.out_load = !status.out_busy;
        if (status.is_del) begin
          cmd.outcome = status.found ? OUT_DELETED : OUT_ABSENT;
        end else if (status.found) begin
          cmd.outcome = OUT_UPDATED;
        end else begin
          cmd.outcome = status.evicted ? OUT_EVICTED : OUT_INSERTED;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/keyed_event_table_upsert.sv =====
// top level of the keyed event table with upsert and oldest-first eviction
// depends on ketu_pkg, ketu_ctrl, ketu_dpath
//
// channel  | direction | tdata                                   | tuser
// in_      | request   | key, start time, length, all-day flag   | is_delete
// out_     | result    | slot, evicted key, entry count          | outcome
//
// one request at a time over a record memory with one write port and a registered read port
// a request runs a key search and a write for update or plain insert, a search and, on a hit, a shift-down
// for delete, and a search, an oldest-record scan, a shift-down and a write for insert with eviction
// rst_n is synchronous; it empties the table and drops any pending result
// a new request is taken while the previous result still waits in the output register
module keyed_event_table_upsert (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] event_key, [95:32] start_time, [127:96] length_seconds, [128] whole_day
  input  logic [ketu_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] is_delete
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [4:0] slot_index, [36:5] evicted_key, [42:37] entry_count
  output logic [ketu_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [2:0] outcome
  output logic [ketu_pkg::CODE_W-1:0]         out_tuser
);
  import ketu_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  entry_t             in_entry;
  logic [SLOT_W-1:0]  res_slot;
  logic [KEY_W-1:0]   res_evicted;
  logic [COUNT_W-1:0] res_count;

  assign in_entry.event_key      = in_tdata[KEY_W-1:0];
  assign in_entry.start_time     = in_tdata[KEY_W+TIME_W-1:KEY_W];
  assign in_entry.length_seconds = in_tdata[KEY_W+TIME_W+LEN_W-1:KEY_W+TIME_W];
  assign in_entry.whole_day      = in_tdata[KEY_W+TIME_W+LEN_W];

  ketu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ketu_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_is_delete (in_tuser),
    .in_entry     (in_entry),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_outcome  (out_tuser),
    .out_slot     (res_slot),
    .out_evicted  (res_evicted),
    .out_count    (res_count)
  );

  assign out_tdata = {{(OUT_DATA_W - SLOT_W - KEY_W - COUNT_W){1'b0}},
                      res_count, res_evicted, res_slot};

endmodule

// ===== tb/ketu_checker.sv =====
// result checker for the keyed event table: mirrors the table, predicts each result
// and compares it with what leaves the out_ channel; depends on ketu_pkg
`timescale 1ns / 1ps
module ketu_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ketu_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ketu_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [ketu_pkg::CODE_W-1:0]     out_tuser,
  output int                              fail_count,
  output int                              pending
);
  import ketu_pkg::*;

  typedef struct packed {
    outcome_t           outcome;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   evicted;
    logic [COUNT_W-1:0] count;
  } table_result_t;

  logic [KEY_W-1:0]         rec_key  [TABLE_DEPTH];
  logic signed [TIME_W-1:0] rec_time [TABLE_DEPTH];
  logic [LEN_W-1:0]         rec_len  [TABLE_DEPTH];
  logic                     rec_day  [TABLE_DEPTH];
  int                       rec_count;
  table_result_t            result_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
    rec_count = 0;
  end

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < rec_count; i++) begin
      rec_key[i]  = rec_key[i+1];
      rec_time[i] = rec_time[i+1];
      rec_len[i]  = rec_len[i+1];
      rec_day[i]  = rec_day[i+1];
    end
    rec_count--;
  endfunction

  function automatic table_result_t apply_request(logic del, logic [KEY_W-1:0] key,
                                                  logic signed [TIME_W-1:0] t,
                                                  logic [LEN_W-1:0] len, logic day);
    table_result_t res;
    int hit;
    int oldest;
    int pos;
    res = '0;
    hit = -1;
    for (int i = 0; i < rec_count; i++) begin
      if (rec_key[i] == key) begin
        hit = i;
        break;
      end
    end
    if (del) begin
      if (hit >= 0) begin
        drop_slot(hit);
        res.outcome = OUT_DELETED;
        res.slot = SLOT_W'(hit);
      end else begin
        res.outcome = OUT_ABSENT;
      end
    end else begin
      if (hit >= 0) begin
        pos = hit;
        res.outcome = OUT_UPDATED;
      end else begin
        res.outcome = OUT_INSERTED;
        if (rec_count >= TABLE_DEPTH) begin
          // oldest start time goes, earliest slot on a tie
          oldest = 0;
          for (int i = 1; i < rec_count; i++) begin
            if (rec_time[i] < rec_time[oldest]) oldest = i;
          end
          res.evicted = rec_key[oldest];
          res.outcome = OUT_EVICTED;
          drop_slot(oldest);
        end
        pos = rec_count;
        rec_count++;
      end
      rec_key[pos]  = key;
      rec_time[pos] = t;
      rec_len[pos]  = len;
      rec_day[pos]  = day;
      res.slot = SLOT_W'(pos);
    end
    res.count = COUNT_W'(rec_count);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    table_result_t got;
    table_result_t want;
    if (!rst_n) begin
      rec_count = 0;
      result_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.outcome = outcome_t'(out_tuser);
        got.slot    = out_tdata[SLOT_W-1:0];
        got.evicted = out_tdata[SLOT_W +: KEY_W];
        got.count   = out_tdata[SLOT_W+KEY_W +: COUNT_W];
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: outcome %0d slot %0d evicted %h count %0d",
                     got.outcome, got.slot, got.evicted, got.count);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("mismatch (exp/got): outcome %0d/%0d slot %0d/%0d ",
                     want.outcome, got.outcome, want.slot, got.slot);
              $display("evicted %h/%h count %0d/%0d",
                       want.evicted, got.evicted, want.count, got.count);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        result_q.insert(result_q.size(),
                        apply_request(in_tuser, in_tdata[0 +: KEY_W],
                                      in_tdata[KEY_W +: TIME_W],
                                      in_tdata[KEY_W+TIME_W +: LEN_W],
                                      in_tdata[KEY_W+TIME_W+LEN_W]));
    end
    pending = result_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// top of the keyed event table testbench: clock, reset, request stimulus and verdict
// depends on ketu_pkg, keyed_event_table_upsert and ketu_checker
`timescale 1ns / 1ps
module testbench;
  import ketu_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [CODE_W-1:0]     out_tuser;
  int                    fail_count;
  int                    pending;
  bit                    no_idle;
  bit                    hold_kick;
  logic [KEY_W-1:0]      key_pool [40];

  keyed_event_table_upsert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ketu_checker watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    int  hold_left;
    bit  hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_kick && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else if (no_idle) begin
        out_tready = 1'b1;
      end else begin
        out_tready = ($urandom_range(0, 99) >= 17);
      end
    end
  end

  task automatic push_request(input logic del, input logic [KEY_W-1:0] key,
                              input logic [TIME_W-1:0] t, input logic [LEN_W-1:0] len,
                              input logic day);
    in_tdata = '0;
    in_tdata[0 +: KEY_W] = key;
    in_tdata[KEY_W +: TIME_W] = t;
    in_tdata[KEY_W+TIME_W +: LEN_W] = len;
    in_tdata[KEY_W+TIME_W+LEN_W] = day;
    in_tuser = del;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 99) < 17) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  initial begin : stimulus
    int wait_cycles;
    int del_pct;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    no_idle = 1'b0;
    hold_kick = 1'b0;
    rst_n = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 40; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // delete on empty table, extremes, update in place, shift on delete, absent keys
    push_request(1'b1, 32'h0, '0, '0, 1'b0);
    push_request(1'b0, 32'h0, {1'b1, 63'b0}, '0, 1'b0);
    push_request(1'b0, '1, {1'b0, {63{1'b1}}}, '1, 1'b1);
    push_request(1'b0, 32'h0, {1'b0, {63{1'b1}}}, '1, 1'b1);
    push_request(1'b0, 32'ha5a5_5a5a, '0, 32'h1234_5678, 1'b0);
    push_request(1'b1, '1, '0, '0, 1'b0);
    push_request(1'b1, '1, '1, '1, 1'b1);
    push_request(1'b0, 32'h0, '1, 32'h0, 1'b0);
    push_request(1'b1, 32'h0, '0, '0, 1'b0);
    push_request(1'b1, 32'ha5a5_5a5a, '0, '0, 1'b0);
    push_request(1'b0, 32'h5a5a_a5a5, {16{4'h5}}, 32'haaaa_aaaa, 1'b1);
    push_request(1'b0, 32'ha5a5_5a5a, {16{4'ha}}, 32'h5555_5555, 1'b0);

    for (int i = 0; i < 1000; i++) begin : rand_item
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] t;
      logic [LEN_W-1:0]  len;
      int                pick;
      case ((i / 120) % 3)
        0:       del_pct = 8;
        1:       del_pct = 35;
        default: del_pct = 75;
      endcase
      no_idle = (i >= 400 && i < 520);
      if (i == 300) hold_kick = 1'b1;
      if (i == 650) begin
        in_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 39)];
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: t = {$urandom, $urandom};
        4, 5, 6:    t = 64'($urandom_range(0, 7)) - 64'd3;
        7:          t = {1'b1, 63'b0};
        8:          t = {1'b0, {63{1'b1}}};
        default:    t = {32'b0, $urandom};
      endcase
      pick = $urandom_range(0, 9);
      len = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
      push_request($urandom_range(0, 99) < del_pct, key, t, len,
                   1'($urandom_range(0, 1)));
    end

    in_tvalid = 1'b0;
    no_idle = 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    if (pending != 0) begin
      $display("FAILURE");
    end else begin
      repeat (150) @(negedge clk);
      if (fail_count == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

endmodule
